// File: rtl/core/r10unp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// r10unp_pkg
// Types and constants shared by the RAW10 row unpacker.
// ----------------------------------------------------------------------------
package r10unp_pkg;

  localparam int BYTE_W     = 8;
  localparam int PIXEL_W    = 10;
  localparam int STRIDE_W   = 14;
  localparam int GROUPS_W   = 12;
  localparam int ROWS_W     = 13;
  localparam int CFG_DATA_W = 14;
  localparam int CFG_IDX_W  = 2;

  localparam int POS_W      = 14;
  localparam int PHASE_W    = 3;
  localparam int GCOUNT_W   = 11;
  localparam int RCOUNT_W   = 12;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUPS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS       = 2'd2;

  // Register values after reset.
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 14'd4128;
  localparam logic [GROUPS_W-1:0] GROUPS_RESET = 12'd820;
  localparam logic [ROWS_W-1:0]   ROWS_RESET   = 13'd2464;

  // Group phase codes: 0..3 collect high bytes, then the split byte, then padding.
  localparam logic [PHASE_W-1:0] PHASE_SPLIT = 3'd4;
  localparam logic [PHASE_W-1:0] PHASE_DONE  = 3'd5;

  // Masks for the low two bits of each pixel within the split byte.
  localparam logic [BYTE_W-1:0] SPLIT_MASK_A = 8'b1100_0000;
  localparam logic [BYTE_W-1:0] SPLIT_MASK_B = 8'b0011_0000;
  localparam logic [BYTE_W-1:0] SPLIT_MASK_C = 8'b0000_1100;
  localparam logic [BYTE_W-1:0] SPLIT_MASK_D = 8'b0000_0011;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_a;
    logic [PIXEL_W-1:0] pixel_b;
    logic [PIXEL_W-1:0] pixel_c;
    logic [PIXEL_W-1:0] pixel_d;
    logic               row_end;
    logic               frame_end;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/core/raw10_row_unpacker_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// raw10_row_unpacker_unit
// Unpacks a RAW10 byte stream, one byte per request, into groups of four
// 10-bit pixels, skipping row padding and flagging row and frame ends.
// ----------------------------------------------------------------------------
// A group's result is registered when its split byte is taken.
// Throughput: one byte per cycle while data_stall is low; the byte counters
// and the 4-byte holding register update together, so bytes stream
// back to back. A result register plus a one-entry skid register let bytes
// keep flowing while the result side stalls until a second group is waiting;
// data_stall rises only when both hold.
// Reset (rst, synchronous): counters clear, config registers load defaults.
// ----------------------------------------------------------------------------
module raw10_row_unpacker_unit #(
  parameter int MAX_ROW_BYTES = 16384,
  parameter int MAX_GROUPS    = 2048,
  parameter int MAX_ROWS      = 4096
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // Configuration write port.
  input  wire logic                                 cfg_write,
  input  wire logic [r10unp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [r10unp_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Byte input channel.
  input  wire logic                                 data_valid,
  output logic                                      data_stall,
  input  wire logic [r10unp_pkg::BYTE_W-1:0]        data_byte,
  // Pixel group output channel.
  output logic                                      pixel_valid,
  input  wire logic                                 pixel_stall,
  output logic [r10unp_pkg::PIXEL_W-1:0]            pixel_a,
  output logic [r10unp_pkg::PIXEL_W-1:0]            pixel_b,
  output logic [r10unp_pkg::PIXEL_W-1:0]            pixel_c,
  output logic [r10unp_pkg::PIXEL_W-1:0]            pixel_d,
  output logic                                      row_end,
  output logic                                      frame_end
);

  localparam int STRIDE_W = r10unp_pkg::STRIDE_W;
  localparam int GROUPS_W = r10unp_pkg::GROUPS_W;
  localparam int ROWS_W   = r10unp_pkg::ROWS_W;
  localparam int POS_W    = r10unp_pkg::POS_W;
  localparam int PHASE_W  = r10unp_pkg::PHASE_W;
  localparam int GCOUNT_W = r10unp_pkg::GCOUNT_W;
  localparam int RCOUNT_W = r10unp_pkg::RCOUNT_W;
  localparam int BYTE_W   = r10unp_pkg::BYTE_W;

  // Configuration registers.
  logic [STRIDE_W-1:0] row_stride_bytes;
  logic [GROUPS_W-1:0] groups_per_row;
  logic [ROWS_W-1:0]   rows_per_frame;

  // Row walking state.
  logic [POS_W-1:0]    byte_position, byte_position_next;
  logic [PHASE_W-1:0]  group_phase, group_phase_next;
  logic [GCOUNT_W-1:0] group_count, group_count_next;
  logic [RCOUNT_W-1:0] row_count, row_count_next;
  logic [BYTE_W-1:0]   high_bytes [4];

  // Result register and skid register.
  r10unp_pkg::result_t out_reg, skid_reg, result;
  logic                out_valid, skid_valid;

  // Effective limits: each register saturates at its parameter. One extra bit
  // holds a limit equal to the register's full range.
  logic [STRIDE_W:0] stride_eff;
  logic [GROUPS_W:0] groups_eff;
  logic [ROWS_W:0]   rows_eff;

  logic accept, out_fire, produce, collecting, last_row, group_last, row_wrap;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_stride_bytes <= r10unp_pkg::STRIDE_RESET;
      groups_per_row   <= r10unp_pkg::GROUPS_RESET;
      rows_per_frame   <= r10unp_pkg::ROWS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        r10unp_pkg::REG_ROW_STRIDE: row_stride_bytes <= cfg_data[STRIDE_W-1:0];
        r10unp_pkg::REG_GROUPS:     groups_per_row   <= cfg_data[GROUPS_W-1:0];
        r10unp_pkg::REG_ROWS:       rows_per_frame   <= cfg_data[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    stride_eff = (32'(row_stride_bytes) > MAX_ROW_BYTES) ?
                 (STRIDE_W+1)'(MAX_ROW_BYTES) : {1'b0, row_stride_bytes};
    groups_eff = (32'(groups_per_row) > MAX_GROUPS) ?
                 (GROUPS_W+1)'(MAX_GROUPS) : {1'b0, groups_per_row};
    rows_eff   = (32'(rows_per_frame) > MAX_ROWS) ?
                 (ROWS_W+1)'(MAX_ROWS) : {1'b0, rows_per_frame};
  end

  // A new byte is taken whenever the skid register is free, so one result can
  // always be parked even if the output side stalls on that same cycle.
  assign data_stall = skid_valid;
  assign accept     = data_valid && !data_stall;
  assign out_fire   = out_valid && !pixel_stall;

  // Per-byte decode. Compares are done at least one bit wider than the
  // counters so the +1 never wraps.
  always_comb begin
    last_row   = ((ROWS_W+1)'(row_count) + 1'b1) >= rows_eff;
    collecting = (group_phase < r10unp_pkg::PHASE_DONE) &&
                 ((GROUPS_W+1)'(group_count) < groups_eff);
    group_last = ((GROUPS_W+1)'(group_count) + 1'b1) >= groups_eff;
    row_wrap   = ((STRIDE_W+1)'(byte_position) + 1'b1) >= stride_eff;
    produce    = accept && collecting && (group_phase == r10unp_pkg::PHASE_SPLIT);

    // The split byte carries the low two bits of all four pixels.
    result.pixel_a   = {high_bytes[0],
                        2'((data_byte & r10unp_pkg::SPLIT_MASK_A) >> 6)};
    result.pixel_b   = {high_bytes[1],
                        2'((data_byte & r10unp_pkg::SPLIT_MASK_B) >> 4)};
    result.pixel_c   = {high_bytes[2],
                        2'((data_byte & r10unp_pkg::SPLIT_MASK_C) >> 2)};
    result.pixel_d   = {high_bytes[3], 2'(data_byte & r10unp_pkg::SPLIT_MASK_D)};
    result.row_end   = group_last;
    result.frame_end = group_last && last_row;

    group_phase_next   = group_phase;
    group_count_next   = group_count;
    byte_position_next = byte_position;
    row_count_next     = row_count;

    if (collecting) begin
      if (group_phase == r10unp_pkg::PHASE_SPLIT) begin
        if (group_last) begin
          // The row's active groups are done; the rest is padding.
          group_phase_next = r10unp_pkg::PHASE_DONE;
        end else begin
          group_count_next = group_count + 1'b1;
          group_phase_next = '0;
        end
      end else begin
        group_phase_next = group_phase + 1'b1;
      end
    end

    if (row_wrap) begin
      // A partly collected group at the row boundary is dropped here.
      byte_position_next = '0;
      group_phase_next   = '0;
      group_count_next   = '0;
      row_count_next     = last_row ? '0 : row_count + 1'b1;
    end else begin
      byte_position_next = byte_position + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      group_phase   <= '0;
      group_count   <= '0;
      row_count     <= '0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      group_phase   <= group_phase_next;
      group_count   <= group_count_next;
      row_count     <= row_count_next;
    end
  end

  // High bytes of the group being collected; only read after being written
  // earlier in the same group.
  always_ff @(posedge clk) begin
    if (accept && collecting && (group_phase < r10unp_pkg::PHASE_SPLIT)) begin
      high_bytes[group_phase[1:0]] <= data_byte;
    end
  end

  // Output register with a one-entry skid behind it. The skid fills only when
  // a result arrives while the output register is held by a stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_fire) begin
      out_valid  <= skid_valid || produce;
      skid_valid <= skid_valid && produce;
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_fire) begin
      out_reg <= skid_valid ? skid_reg : result;
      if (skid_valid) begin
        skid_reg <= result;
      end
    end else if (produce) begin
      skid_reg <= result;
    end
  end

  assign pixel_valid = out_valid;
  assign pixel_a     = out_reg.pixel_a;
  assign pixel_b     = out_reg.pixel_b;
  assign pixel_c     = out_reg.pixel_c;
  assign pixel_d     = out_reg.pixel_d;
  assign row_end     = out_reg.row_end;
  assign frame_end   = out_reg.frame_end;

endmodule
`default_nettype wire
